FILE: sv/fsd_pkg.sv
// ----------------------------------------------------------------------------
// fsd_pkg
// shared types and constants of the false sharing detector
// ----------------------------------------------------------------------------
`default_nettype none
package fsd_pkg;
	localparam int TABLE_ENTRIES = 1024;
	localparam int THREADS       = 32;
	localparam int ADDRESS_BITS  = 48;
	localparam int WORD_MASK_W   = 16;
	localparam int TID_W         = 5;
	localparam int CNT_W         = 11;
	localparam int ENTRY_W       = $clog2(TABLE_ENTRIES);
	localparam int TAG_W         = ADDRESS_BITS - 6;
	localparam int ROW_W         = THREADS * WORD_MASK_W;
	localparam int LANE_W        = $clog2(ROW_W);

	localparam logic REQ_REF    = 1'b0;
	localparam logic REQ_REPORT = 1'b1;

	typedef logic [TAG_W-1:0] tag_t;
	typedef logic [ROW_W-1:0] row_t;

	// one tag cell as seen by its neighbor
	typedef struct packed {
		logic valid;
		tag_t tag;
	} link_t;

	// two or more masks nonzero and no word bit shared by two masks
	function automatic logic row_false_shared(input row_t row);
		logic [WORD_MASK_W-1:0] one_v;
		logic [WORD_MASK_W-1:0] two_v;
		logic                   u_one;
		logic                   u_two;
		logic [WORD_MASK_W-1:0] m;
		one_v = '0;
		two_v = '0;
		u_one = 1'b0;
		u_two = 1'b0;
		for (int t = 0; t < THREADS; t++) begin
			m     = row[t*WORD_MASK_W +: WORD_MASK_W];
			two_v = two_v | (one_v & m);
			one_v = one_v | m;
			u_two = u_two | (u_one & (|m));
			u_one = u_one | (|m);
		end
		return u_two & ~(|two_v);
	endfunction
endpackage
`default_nettype wire

FILE: sv/fsd_in_if.sv
// ----------------------------------------------------------------------------
// fsd_in_if
// request channel: memory reference or report request
// ----------------------------------------------------------------------------
`default_nettype none
interface fsd_in_if import fsd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    req_type;
	logic [TID_W-1:0]        thread_id;
	logic [ADDRESS_BITS-1:0] address;
	modport source (output valid, req_type, thread_id, address, input ready);
	modport sink (input valid, req_type, thread_id, address, output ready);
endinterface
`default_nettype wire

FILE: sv/fsd_out_if.sv
// ----------------------------------------------------------------------------
// fsd_out_if
// result channel: one result per request
// ----------------------------------------------------------------------------
`default_nettype none
interface fsd_out_if import fsd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             dropped;
	logic [CNT_W-1:0] blocks_seen;
	logic [CNT_W-1:0] falsely_shared_count;
	logic             overflow_seen;
	modport source (output valid, dropped, blocks_seen, falsely_shared_count,
		overflow_seen, input ready);
	modport sink (input valid, dropped, blocks_seen, falsely_shared_count,
		overflow_seen, output ready);
endinterface
`default_nettype wire

FILE: sv/false_sharing_detector_core.sv
// ----------------------------------------------------------------------------
// false_sharing_detector_core
// tracks per-thread word masks of 64-byte blocks and reports false sharing
// ----------------------------------------------------------------------------
// usage
//   in_ch carries requests: req_type 0 records a reference of thread_id to
//   address, req_type 1 asks for a report. every request yields exactly one
//   transfer on out_ch, in request order.
//   a reference to a block already held passes tag search, mask row read and
//   row write; one that allocates writes its new row during the tag search,
//   and a dropped one ends after the tag search. a report walks the held
//   entries through the mask row memory, one row per cycle.
//   tags sit in a chain of cells; a new block shifts in at the head, so cell
//   k holds entry entries_used-1-k. all cells compare the key in parallel.
//   the mask row of a new entry is written whole, so the row memory needs
//   no clearing pass after reset.
//   one request is in flight at a time; the next is taken as soon as the
//   result is parked in the output register, even if out_ch is stalled.
//   a stalled out_ch holds the result and keeps the core from finishing
//   the following request.
//   reset empties the table, clears the overflow flag and the output.
// ----------------------------------------------------------------------------
`default_nettype none
module false_sharing_detector_core import fsd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	fsd_in_if.sink     in_ch,
	fsd_out_if.source  out_ch
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_READ,
		S_REP,
		S_DONE
	} state_t;

	state_t               state_q;
	tag_t                 key_q;
	logic [TID_W-1:0]     tid_q;
	logic [3:0]           word_q;
	logic [CNT_W-1:0]     used_q;
	logic                 ovf_q;
	logic [CNT_W-1:0]     iss_q;
	logic                 pend_q;
	logic [CNT_W-1:0]     fs_q;
	logic [ENTRY_W-1:0]   ent_q;
	logic                 res_drop_q;
	logic                 res_rep_q;
	logic                 out_valid_q;
	logic                 out_drop_q;
	logic [CNT_W-1:0]     out_seen_q;
	logic [CNT_W-1:0]     out_fs_q;
	logic                 out_ovf_q;

	// tag chain
	link_t                links [TABLE_ENTRIES+1];
	logic [TABLE_ENTRIES-1:0] hits;
	logic                 shift;
	logic                 any_hit;
	logic [ENTRY_W-1:0]   hit_pos;
	logic [ENTRY_W-1:0]   hit_ent;

	assign links[0].valid = 1'b1;
	assign links[0].tag   = key_q;

	for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
		fsd_tag_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (shift),
			.prev  (links[k]),
			.key   (key_q),
			.cur   (links[k+1]),
			.hit   (hits[k])
		);
	end

	// tags are unique, so at most one hit: or the positions together
	always_comb begin
		hit_pos = '0;
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			if (hits[k]) begin
				hit_pos = hit_pos | ENTRY_W'(k);
			end
		end
	end
	assign any_hit = |hits;
	assign hit_ent = ENTRY_W'(used_q - CNT_W'(1) - CNT_W'(hit_pos));

	wire logic full = (used_q == CNT_W'(TABLE_ENTRIES));
	assign shift = (state_q == S_LOOK) && !any_hit && !full;

	// mask rows
	logic               wr_en;
	logic [ENTRY_W-1:0] wr_addr;
	row_t               wr_data;
	logic               rd_en;
	logic [ENTRY_W-1:0] rd_addr;
	row_t               rd_data;
	row_t               lane;

	assign lane = row_t'(1) << (LANE_W'(tid_q) * LANE_W'(WORD_MASK_W) + LANE_W'(word_q));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ent_q;
		wr_data = rd_data | lane;
		rd_en   = 1'b0;
		rd_addr = iss_q[ENTRY_W-1:0];
		unique case (state_q)
			S_LOOK: begin
				if (any_hit) begin
					rd_en   = 1'b1;
					rd_addr = hit_ent;
				end else if (!full) begin
					wr_en   = 1'b1;
					wr_addr = used_q[ENTRY_W-1:0];
					wr_data = lane;
				end
			end
			S_READ: begin
				wr_en = 1'b1;
			end
			S_REP: begin
				rd_en = (iss_q != used_q);
			end
			default: ;
		endcase
	end

	fsd_mask_ram u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign in_ch.ready = (state_q == S_IDLE);
	wire logic in_xfer  = in_ch.valid && in_ch.ready;
	wire logic out_xfer = out_valid_q && out_ch.ready;
	wire logic tid_bad  = ({1'b0, in_ch.thread_id} >= (TID_W+1)'(THREADS));

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			key_q  <= in_ch.address[ADDRESS_BITS-1:6];
			word_q <= in_ch.address[5:2];
			tid_q  <= in_ch.thread_id;
		end
		if (state_q == S_LOOK) begin
			ent_q <= hit_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			ovf_q       <= 1'b0;
			iss_q       <= '0;
			pend_q      <= 1'b0;
			fs_q        <= '0;
			res_drop_q  <= 1'b0;
			res_rep_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_drop_q  <= 1'b0;
			out_seen_q  <= '0;
			out_fs_q    <= '0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						res_drop_q <= 1'b0;
						res_rep_q  <= 1'b0;
						if (in_ch.req_type == REQ_REPORT) begin
							res_rep_q <= 1'b1;
							iss_q     <= '0;
							pend_q    <= 1'b0;
							fs_q      <= '0;
							state_q   <= S_REP;
						end else if (tid_bad) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_LOOK;
						end
					end
				end
				S_LOOK: begin
					if (any_hit) begin
						state_q <= S_READ;
					end else if (!full) begin
						used_q  <= used_q + CNT_W'(1);
						state_q <= S_DONE;
					end else begin
						res_drop_q <= 1'b1;
						ovf_q      <= 1'b1;
						state_q    <= S_DONE;
					end
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_REP: begin
					// issue one row a cycle, count the row read last cycle
					if (rd_en) begin
						iss_q <= iss_q + CNT_W'(1);
					end
					pend_q <= rd_en;
					if (pend_q && row_false_shared(rd_data)) begin
						fs_q <= fs_q + CNT_W'(1);
					end
					if (!rd_en && !pend_q) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_drop_q  <= res_drop_q;
						out_seen_q  <= res_rep_q ? used_q : '0;
						out_fs_q    <= res_rep_q ? fs_q : '0;
						out_ovf_q   <= ovf_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid                = out_valid_q;
	assign out_ch.dropped              = out_drop_q;
	assign out_ch.blocks_seen          = out_seen_q;
	assign out_ch.falsely_shared_count = out_fs_q;
	assign out_ch.overflow_seen        = out_ovf_q;
endmodule
`default_nettype wire

FILE: sv/fsd_tag_cell.sv
// ----------------------------------------------------------------------------
// fsd_tag_cell
// one block tag of the tag chain, compares against the broadcast key
// ----------------------------------------------------------------------------
`default_nettype none
module fsd_tag_cell import fsd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  shift,
	input  wire link_t prev,
	input  wire tag_t  key,
	output link_t      cur,
	output logic       hit
);
	logic valid_q;
	tag_t tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			tag_q <= prev.tag;
		end
	end

	assign cur.valid = valid_q;
	assign cur.tag   = tag_q;
	assign hit       = valid_q && (tag_q == key);
endmodule
`default_nettype wire

FILE: sv/fsd_mask_ram.sv
// ----------------------------------------------------------------------------
// fsd_mask_ram
// per-entry row of thread word masks, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module fsd_mask_ram import fsd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               wr_en,
	input  wire logic [ENTRY_W-1:0] wr_addr,
	input  wire row_t               wr_data,
	input  wire logic               rd_en,
	input  wire logic [ENTRY_W-1:0] rd_addr,
	output row_t                    rd_data
);
	row_t mem [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

FILE: tb/fsd_scoreboard.sv
// ----------------------------------------------------------------------------
// fsd_scoreboard
// predicts detector results and checks them in order
// ----------------------------------------------------------------------------
`default_nettype none
package fsd_scoreboard_pkg;
	import fsd_pkg::*;

	typedef struct packed {
		logic             dropped;
		logic [CNT_W-1:0] blocks_seen;
		logic [CNT_W-1:0] falsely_shared_count;
		logic             overflow_seen;
	} fsd_result_t;

	class fsd_scoreboard;
		bit                     held [TABLE_ENTRIES];
		tag_t                   tags [TABLE_ENTRIES];
		logic [WORD_MASK_W-1:0] masks [TABLE_ENTRIES][THREADS];
		int                     used;
		bit                     overflow;
		fsd_result_t            pending [$];
		int                     errors;

		function void clear();
			foreach (held[e]) begin
				held[e] = 0;
				tags[e] = '0;
				for (int t = 0; t < THREADS; t++) masks[e][t] = '0;
			end
			used = 0;
			overflow = 0;
		endfunction

		// apply an accepted request and queue its expected result
		function void note_request(logic req, logic [TID_W-1:0] tid,
			logic [ADDRESS_BITS-1:0] addr);
			fsd_result_t r;
			int hit, valid_n, fs_n, users;
			logic [WORD_MASK_W-1:0] seen;
			bit ovl;
			tag_t tag;
			r = '0;
			if (req == REQ_REPORT) begin
				valid_n = 0;
				fs_n = 0;
				for (int e = 0; e < TABLE_ENTRIES; e++) if (held[e]) begin
					valid_n++;
					users = 0;
					seen = '0;
					ovl = 0;
					for (int t = 0; t < THREADS; t++) if (masks[e][t] != 0) begin
						users++;
						if ((seen & masks[e][t]) != 0) ovl = 1;
						seen |= masks[e][t];
					end
					if (users > 1 && !ovl) fs_n++;
				end
				r.blocks_seen = (valid_n > 2047) ? CNT_W'(2047) : CNT_W'(valid_n);
				r.falsely_shared_count = (fs_n > 2047) ? CNT_W'(2047) : CNT_W'(fs_n);
			end else begin
				tag = addr[ADDRESS_BITS-1:6];
				hit = -1;
				for (int e = 0; e < used; e++)
					if (held[e] && tags[e] == tag) begin
						hit = e;
						break;
					end
				if (hit < 0) begin
					if (used < TABLE_ENTRIES) begin
						hit = used;
						held[hit] = 1;
						tags[hit] = tag;
						used++;
					end else begin
						r.dropped = 1;
						overflow = 1;
					end
				end
				if (hit >= 0) masks[hit][tid][addr[5:2]] = 1'b1;
			end
			r.overflow_seen = overflow;
			pending = {pending, r};
		endfunction

		function void check_result(fsd_result_t got);
			fsd_result_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.dropped !== exp.dropped)
				$display("%0t: dropped exp %0d got %0d", $time, exp.dropped, got.dropped);
			if (got.blocks_seen !== exp.blocks_seen)
				$display("%0t: blocks_seen exp %0d got %0d", $time,
					exp.blocks_seen, got.blocks_seen);
			if (got.falsely_shared_count !== exp.falsely_shared_count)
				$display("%0t: falsely_shared_count exp %0d got %0d", $time,
					exp.falsely_shared_count, got.falsely_shared_count);
			if (got.overflow_seen !== exp.overflow_seen)
				$display("%0t: overflow_seen exp %0d got %0d", $time,
					exp.overflow_seen, got.overflow_seen);
			if (got !== exp) errors++;
		endfunction
	endclass
endpackage
`default_nettype wire

FILE: tb/false_sharing_detector_core_tb.sv
// ----------------------------------------------------------------------------
// false_sharing_detector_core_tb
// drives references and reports with random gaps and stalls, checks every
// result against a behavioral predictor of the block table and word masks
// ----------------------------------------------------------------------------
`default_nettype none
module false_sharing_detector_core_tb;
	import fsd_pkg::*;
	import fsd_scoreboard_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;
	fsd_in_if  in_ch ();
	fsd_out_if out_ch ();

	false_sharing_detector_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	fsd_scoreboard sb;
	int            idle_cycles;
	logic [ADDRESS_BITS-1:0] base_addrs [8];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// one request transfer, with a random gap before it
	task automatic send_request(logic req, logic [TID_W-1:0] tid,
		logic [ADDRESS_BITS-1:0] addr);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.req_type  <= req;
		in_ch.thread_id <= tid;
		in_ch.address   <= addr;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_request(req, tid, addr);
	endtask

	task automatic send_ref(logic [TID_W-1:0] tid, logic [ADDRESS_BITS-1:0] addr);
		send_request(REQ_REF, tid, addr);
	endtask

	task automatic send_report();
		send_request(REQ_REPORT, TID_W'($urandom), ADDRESS_BITS'({$urandom, $urandom}));
	endtask

	// random address near one of a few hot blocks, so hits and sharing happen
	function automatic logic [ADDRESS_BITS-1:0] hot_addr();
		logic [ADDRESS_BITS-1:0] a;
		a = base_addrs[$urandom_range(0, 7)];
		a[5:0] = 6'($urandom);
		return a;
	endfunction

	function automatic logic [ADDRESS_BITS-1:0] rand_addr();
		return ADDRESS_BITS'({$urandom, $urandom});
	endfunction

	// receiver: random stall before every transfer
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			stall = $urandom_range(0, 3);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			sb.check_result('{out_ch.dropped, out_ch.blocks_seen,
				out_ch.falsely_shared_count, out_ch.overflow_seen});
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		sb = new();
		sb.clear();
		idle_cycles = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.req_type = REQ_REF;
		in_ch.thread_id = '0;
		in_ch.address = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty report, extremes, false and true sharing
		send_report();
		send_ref(5'd0, '0);
		send_ref(5'd31, '1);
		send_ref(5'd1, 48'h0000_0000_0004);    // same block, other word: false share
		send_ref(5'd2, 48'h0000_0000_0003);    // same word as thread 0: true share
		send_ref(5'd5, 48'hAAAA_AAAA_AA80);
		send_ref(5'd6, 48'h5555_5555_5540);
		send_ref(5'd5, 48'hAAAA_AAAA_AABC);    // same thread twice, word 15
		send_ref(5'd6, 48'hAAAA_AAAA_AA84);    // disjoint words
		send_ref(5'd31, 48'hFFFF_FFFF_FFC0);
		send_report();
		send_ref(5'd3, 48'h5555_5555_557C);
		send_ref(5'd4, 48'h5555_5555_557C);    // overlapping masks
		send_report();

		foreach (base_addrs[i]) base_addrs[i] = rand_addr();

		// random mix, mostly hot blocks, a few fresh ones, rare reports
		for (int n = 0; n < 600; n++) begin
			if ($urandom_range(0, 29) == 0) send_report();
			else if ($urandom_range(0, 3) == 0) send_ref(TID_W'($urandom), rand_addr());
			else send_ref(TID_W'($urandom), hot_addr());
			if ($urandom_range(0, 99) == 0) base_addrs[$urandom_range(0, 7)] =
				rand_addr();
		end
		send_report();

		// more fresh blocks and more frequent reports
		for (int n = 0; n < 120; n++) begin
			if ($urandom_range(0, 9) == 0) send_report();
			else if ($urandom_range(0, 1) == 0) send_ref(TID_W'($urandom), rand_addr());
			else send_ref(TID_W'($urandom), hot_addr());
		end
		send_report();
		in_ch.valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire
